@@ hw/rtl/tlt_pkg.sv @@
// Shared constants for the tilt and heading block: default parameter values,
// CORDIC angle table in Q24 degrees and fixed internal widths.
// No dependencies.
package tlt_pkg;

  localparam int DEF_SAMPLE_WIDTH    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 6;
  localparam int DEF_CORDIC_STAGES   = 16;

  // Angle table fraction bits and length, input scale shift, angle accumulator width
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;
  localparam int IN_SHIFT   = 16;
  localparam int ZW         = 35;

  // atan(2^-i) in degrees, Q24
  localparam logic signed [ZW-1:0] ATAN_Q24 [TABLE_LEN] = '{
    35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
    35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
    35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
    35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
    35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
    35'sd917,       35'sd458,       35'sd229,       35'sd115
  };

endpackage

@@ hw/rtl/tlt_isqrt.sv @@
// Pipelined floor integer square root, one result bit per stage.
// Depends on nothing; advances on en.
module tlt_isqrt #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] value,
  output logic [RW-1:0]   root
);

  localparam int VW   = 2 * RW;
  localparam int REMW = RW + 3;

  logic [VW-1:0]   v_s   [0:RW];
  logic [REMW-1:0] rem_s [0:RW];
  logic [RW-1:0]   q_s   [0:RW];

  assign v_s[0]   = value;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;

    always_comb begin
      rem_sh = {rem_s[k][REMW-3:0], v_s[k][VW-1:VW-2]};
      trial  = {1'b0, q_s[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_s[k+1] <= {v_s[k][VW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_s[k+1] <= rem_sh - trial;
          q_s[k+1]   <= {q_s[k][RW-2:0], 1'b1};
        end else begin
          rem_s[k+1] <= rem_sh;
          q_s[k+1]   <= {q_s[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_s[RW];

endmodule

@@ hw/rtl/tlt_cordic.sv @@
// Pipelined vectoring CORDIC atan2(a, b) in 2^-FRAC degree units.
// Depends on tlt_pkg for the angle table.
module tlt_cordic
  import tlt_pkg::*;
#(
  parameter int IW     = 17,
  parameter int FRAC   = 6,
  parameter int STAGES = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [IW-1:0]     a,
  input  logic signed [IW-1:0]     b,
  output logic signed [FRAC+9:0]   angle
);

  localparam int AW = FRAC + 10;
  localparam int CW = IW + IN_SHIFT + 3;
  localparam int RSH = TABLE_FRAC - FRAC;
  localparam logic signed [ZW-1:0] Z180 = ZW'(180) <<< TABLE_FRAC;
  localparam logic signed [ZW-1:0] RND  = ZW'(1) <<< (RSH - 1);
  localparam logic signed [AW-1:0] A180 = AW'(180) <<< FRAC;
  localparam logic signed [AW-1:0] A90  = AW'(90) <<< FRAC;

  logic signed [CW-1:0] x_s  [0:STAGES];
  logic signed [CW-1:0] y_s  [0:STAGES];
  logic signed [ZW-1:0] z_s  [0:STAGES];
  logic                 sp_s [0:STAGES];
  logic signed [AW-1:0] sv_s [0:STAGES];

  logic signed [CW-1:0] a_sc, b_sc;
  logic signed [ZW-1:0] rsum, rsh;

  always_comb begin
    a_sc = CW'(a) <<< IN_SHIFT;
    b_sc = CW'(b) <<< IN_SHIFT;
  end

  // Exact cases bypass the iterations; a negative b is turned by 180 first
  always_ff @(posedge clk) begin
    if (en) begin
      sp_s[0] <= (a == 0) || (b == 0);
      if (a == 0) begin
        sv_s[0] <= (b < 0) ? A180 : '0;
      end else begin
        sv_s[0] <= (a > 0) ? A90 : -A90;
      end
      if (b < 0) begin
        x_s[0] <= -b_sc;
        y_s[0] <= -a_sc;
        z_s[0] <= (a >= 0) ? Z180 : -Z180;
      end else begin
        x_s[0] <= b_sc;
        y_s[0] <= a_sc;
        z_s[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        sp_s[i+1] <= sp_s[i];
        sv_s[i+1] <= sv_s[i];
        if (y_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + ATAN_Q24[i];
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - ATAN_Q24[i];
        end
      end
    end
  end

  // Round half up to the output unit
  always_comb begin
    rsum = z_s[STAGES] + RND;
    rsh  = rsum >>> RSH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= sp_s[STAGES] ? sv_s[STAGES] : rsh[AW-1:0];
    end
  end

endmodule

@@ hw/rtl/tilt_heading_from_accel_mag.sv @@
// Top level of the tilt and heading block: capture, squares, square root,
// two CORDIC units and the held-angle output register.
// Depends on tlt_pkg, tlt_isqrt and tlt_cordic.
//
// Usage: each input beat carries one three-axis sample. action 0 marks an
// accelerometer sample and updates roll and pitch; action 1 marks a
// magnetometer sample and updates heading (declination subtracted, wrapped
// into 0..360 degrees). Every input beat yields one output beat carrying the
// three held angles in 2^-ANGLE_FRAC_BITS degree units.
// Throughput: one beat per cycle while no output beat is stalled. The square
// root works one bit per stage, and its result feeds the pitch CORDIC.
// The declination register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while no beat is in flight.
// Reset (rst, synchronous) clears all held angles, the declination and every
// pipeline valid bit. When the receiver stalls a waiting output beat, the
// whole pipeline holds and in_stall rises in the same cycle; nothing is lost.
module tilt_heading_from_accel_mag
  import tlt_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    y_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    z_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ANGLE_FRAC_BITS+8:0] roll,
  output logic signed [ANGLE_FRAC_BITS+7:0] pitch,
  output logic [ANGLE_FRAC_BITS+8:0]        heading,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [ANGLE_FRAC_BITS+8:0] cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int IW   = SW + 1;
  localparam int AW   = F + 10;
  localparam int HW   = F + 12;
  localparam int CLAT = CORDIC_STAGES + 2;
  localparam logic signed [AW-1:0] A180 = AW'(180) <<< F;
  localparam logic signed [AW-1:0] A90  = AW'(90) <<< F;
  localparam logic signed [HW-1:0] FT   = HW'(360) <<< F;

  logic adv;
  logic signed [F+8:0] declination;

  // Front stages
  logic                 v0, v1, v2;
  logic                 a0, a1;
  logic signed [SW-1:0] x0, y0, z0, x1, y1, z1;
  logic [2*SW-1:0]      yy1, zz1, sum2;

  // Sideband line beside the square root
  logic                 sbv [0:SW];
  logic                 sba [0:SW];
  logic signed [SW-1:0] sbx [0:SW];
  logic signed [SW-1:0] sby [0:SW];
  logic signed [SW-1:0] sbz [0:SW];

  logic [SW-1:0]        root;
  logic signed [IW-1:0] ua_a, ua_b, ub_a, ub_b;
  logic signed [AW-1:0] ang_a, ang_b;

  // Sideband line beside the CORDIC units
  logic cl_v [1:CLAT];
  logic cl_a [1:CLAT];

  logic signed [HW-1:0] h_raw, h_lo, h_wrap;
  logic signed [AW-1:0] roll_c, pitch_c;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= '0;
    end else if (cfg_valid) begin
      declination <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0     <= action;
      x0     <= x_value;
      y0     <= y_value;
      z0     <= z_value;
      a1     <= a0;
      x1     <= x0;
      y1     <= y0;
      z1     <= z0;
      yy1    <= $unsigned((2*SW)'(y0) * (2*SW)'(y0));
      zz1    <= $unsigned((2*SW)'(z0) * (2*SW)'(z0));
      sum2   <= yy1 + zz1;
      sba[0] <= a1;
      sbx[0] <= x1;
      sby[0] <= y1;
      sbz[0] <= z1;
    end
  end

  assign sbv[0] = v2;

  for (genvar k = 0; k < SW; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (rst) begin
        sbv[k+1] <= 1'b0;
      end else if (adv) begin
        sbv[k+1] <= sbv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sba[k+1] <= sba[k];
        sbx[k+1] <= sbx[k];
        sby[k+1] <= sby[k];
        sbz[k+1] <= sbz[k];
      end
    end
  end

  tlt_isqrt #(
    .RW (SW)
  ) u_isqrt (
    .clk   (clk),
    .en    (adv),
    .value (sum2),
    .root  (root)
  );

  // Unit A: roll atan2(y, z) or heading atan2(x, y); y zero maps onto 0 or 180
  always_comb begin
    if (sba[SW]) begin
      if (sby[SW] == 0) begin
        ua_a = '0;
        ua_b = (sbx[SW] < 0) ? -IW'(1) : IW'(1);
      end else begin
        ua_a = IW'(sbx[SW]);
        ua_b = IW'(sby[SW]);
      end
    end else begin
      ua_a = IW'(sby[SW]);
      ua_b = IW'(sbz[SW]);
    end
    ub_a = -IW'(sbx[SW]);
    ub_b = IW'({1'b0, root});
  end

  tlt_cordic #(
    .IW     (IW),
    .FRAC   (F),
    .STAGES (CORDIC_STAGES)
  ) u_cordic_a (
    .clk   (clk),
    .en    (adv),
    .a     (ua_a),
    .b     (ua_b),
    .angle (ang_a)
  );

  tlt_cordic #(
    .IW     (IW),
    .FRAC   (F),
    .STAGES (CORDIC_STAGES)
  ) u_cordic_b (
    .clk   (clk),
    .en    (adv),
    .a     (ub_a),
    .b     (ub_b),
    .angle (ang_b)
  );

  for (genvar k = 1; k <= CLAT; k++) begin : g_cl
    always_ff @(posedge clk) begin
      if (rst) begin
        cl_v[k] <= 1'b0;
      end else if (adv) begin
        cl_v[k] <= (k == 1) ? sbv[SW] : cl_v[(k == 1) ? 1 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cl_a[k] <= (k == 1) ? sba[SW] : cl_a[(k == 1) ? 1 : k-1];
      end
    end
  end

  // Saturate tilt, subtract declination and wrap heading
  always_comb begin
    roll_c  = ang_a;
    if (ang_a > A180) roll_c = A180;
    if (ang_a < -A180) roll_c = -A180;
    pitch_c = ang_b;
    if (ang_b > A90) pitch_c = A90;
    if (ang_b < -A90) pitch_c = -A90;

    h_raw = HW'(ang_a) - HW'(declination);
    h_lo  = h_raw + FT;
    if (h_raw >= FT) begin
      h_wrap = h_raw - FT;
    end else if (h_raw < 0) begin
      h_wrap = (h_lo < 0) ? h_lo + FT : h_lo;
    end else begin
      h_wrap = h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      roll      <= '0;
      pitch     <= '0;
      heading   <= '0;
    end else if (adv) begin
      out_valid <= cl_v[CLAT];
      if (cl_v[CLAT]) begin
        if (cl_a[CLAT]) begin
          heading <= h_wrap[F+8:0];
        end else begin
          roll  <= roll_c[F+8:0];
          pitch <= pitch_c[F+7:0];
        end
      end
    end
  end

endmodule
